// ===== rtl/edct_pkg.sv =====
// Shared types and constants for the event debounce counter table.
`default_nettype none
package edct_pkg;

    localparam int DEF_NUM_EVENTS  = 4;
    localparam int DEF_COUNT_WIDTH = 8;
    localparam int MAX_COUNT_WIDTH = 16;
    localparam int TABLE_SLOTS     = 4;

    localparam int ID_WIDTH     = 16;
    localparam int KIND_WIDTH   = 2;
    localparam int THR_WIDTH    = 8;
    localparam int USE_WIDTH    = 3;
    localparam int NVM_CNT_W    = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_PASSED    = 2'd0,
        KIND_FAILED    = 2'd1,
        KIND_PREPASSED = 2'd2,
        KIND_PREFAILED = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_IN_USE    = 3'd1,
        REG_ID_0      = 3'd2,
        REG_ID_1      = 3'd3,
        REG_ID_2      = 3'd4,
        REG_ID_3      = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        RES_ACCEPTED = 1'b0,
        RES_UNKNOWN  = 1'b1
    } result_t;

    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // report beat taken, update table and result register
        logic cfg_wr;   // config beat taken
    } cmd_t;

    localparam logic [THR_WIDTH-1:0]  RST_THRESHOLD = 8'd8;
    localparam logic [USE_WIDTH-1:0]  RST_IN_USE    = 3'd1;
    localparam logic [ID_WIDTH-1:0]   RST_ID_0      = 16'd1;
    localparam logic [ID_WIDTH-1:0]   RST_ID_OTHER  = 16'd0;

endpackage
`default_nettype wire

// ===== rtl/edct_if.sv =====
// Channel interfaces: report input, result output and config writes.
`default_nettype none
interface edct_report_if
    import edct_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [ID_WIDTH-1:0]   event_id;
    logic [KIND_WIDTH-1:0] report_kind;

    modport source (output valid, output event_id, output report_kind, input ready);
    modport sink   (input valid, input event_id, input report_kind, output ready);
endinterface

interface edct_result_if
    import edct_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 result_code;
    logic [ID_WIDTH-1:0]  nvm_block_id;
    logic [NVM_CNT_W-1:0] nvm_counter_value;
    logic                 event_failed;

    modport source (output valid, output result_code, output nvm_block_id,
                    output nvm_counter_value, output event_failed, input ready);
    modport sink   (input valid, input result_code, input nvm_block_id,
                    input nvm_counter_value, input event_failed, output ready);
endinterface

interface edct_cfg_if
    import edct_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/edct_ctrl.sv =====
// Handshake controller: tracks the result register and issues datapath commands.
`default_nettype none
module edct_ctrl
    import edct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   take;

    // A new report may enter whenever the result register is empty or drains now.
    assign take = in_valid && ((state_reg == ST_EMPTY) || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (take)
                    state_next = ST_FULL;
            end
            ST_FULL:
            begin
                if (out_ready && !take)
                    state_next = ST_EMPTY;
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == ST_EMPTY) || out_ready;
        out_valid  = (state_reg == ST_FULL);
        cfg_ready  = 1'b1;
        cmd.load   = take;
        cmd.cfg_wr = cfg_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ===== rtl/edct_datapath.sv =====
// Datapath: config registers, id match, debounce counters and result register.
`default_nettype none
module edct_datapath
    import edct_pkg::*;
#(
    parameter int NUM_EVENTS  = DEF_NUM_EVENTS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire logic [ID_WIDTH-1:0]   event_id,
    input  wire logic [KIND_WIDTH-1:0] report_kind,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       result_code,
    output logic [ID_WIDTH-1:0]        nvm_block_id,
    output logic [NVM_CNT_W-1:0]       nvm_counter_value,
    output logic                       event_failed
);

    localparam logic [MAX_COUNT_WIDTH-1:0] COUNT_MAX =
        MAX_COUNT_WIDTH'((32'd1 << COUNT_WIDTH) - 32'd1);

    logic [THR_WIDTH-1:0]   thr_reg;
    logic [USE_WIDTH-1:0]   in_use_reg;
    logic [ID_WIDTH-1:0]    id_reg [TABLE_SLOTS];
    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_EVENTS];
    logic [NUM_EVENTS-1:0]  fail_reg;

    logic [NUM_EVENTS-1:0]      hit;
    logic                       found;
    logic [COUNT_WIDTH-1:0]     cnt_cur;
    logic                       fail_cur;
    logic [COUNT_WIDTH-1:0]     cnt_next;
    logic                       fail_next;
    logic [MAX_COUNT_WIDTH-1:0] thr_wide;
    logic [COUNT_WIDTH-1:0]     thr_eff;
    logic [MAX_COUNT_WIDTH-1:0] cnt_next_wide;

    // Threshold clipped to the counter range
    always_comb
    begin
        thr_wide = MAX_COUNT_WIDTH'(thr_reg);
        thr_eff  = (thr_wide > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX)
                                          : COUNT_WIDTH'(thr_wide);
    end

    // Lowest matching entry among those in use, as a one-hot vector
    always_comb
    begin
        logic seen;
        seen     = 1'b0;
        cnt_cur  = '0;
        fail_cur = 1'b0;
        for (int i = 0; i < NUM_EVENTS; i++)
        begin
            hit[i] = !seen && (USE_WIDTH'(i) < in_use_reg) && (id_reg[i] == event_id);
            seen   = seen || hit[i];
            cnt_cur  = cnt_cur | (cnt_reg[i] & {COUNT_WIDTH{hit[i]}});
            fail_cur = fail_cur | (fail_reg[i] & hit[i]);
        end
        found = seen;
    end

    always_comb
    begin
        cnt_next  = cnt_cur;
        fail_next = fail_cur;
        case (kind_t'(report_kind))
            KIND_PREPASSED:
            begin
                cnt_next = (cnt_cur != '0) ? cnt_cur - COUNT_WIDTH'(1) : '0;
                if (cnt_next == '0)
                    fail_next = 1'b0;
            end
            KIND_PREFAILED:
            begin
                // an over-threshold count snaps back to the threshold
                cnt_next = (cnt_cur < thr_eff) ? cnt_cur + COUNT_WIDTH'(1) : thr_eff;
                if (cnt_next == thr_eff)
                    fail_next = 1'b1;
            end
            KIND_FAILED:
            begin
                cnt_next  = thr_eff;
                fail_next = 1'b1;
            end
            default:
            begin
                cnt_next  = '0;
                fail_next = 1'b0;
            end
        endcase
        cnt_next_wide = MAX_COUNT_WIDTH'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= RST_THRESHOLD;
            in_use_reg <= RST_IN_USE;
            id_reg[0]  <= RST_ID_0;
            for (int i = 1; i < TABLE_SLOTS; i++)
                id_reg[i] <= RST_ID_OTHER;
        end
        else if (cmd.cfg_wr)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg    <= cfg_data[THR_WIDTH-1:0];
                REG_IN_USE:    in_use_reg <= cfg_data[USE_WIDTH-1:0];
                REG_ID_0:      id_reg[0]  <= cfg_data;
                REG_ID_1:      id_reg[1]  <= cfg_data;
                REG_ID_2:      id_reg[2]  <= cfg_data;
                REG_ID_3:      id_reg[3]  <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_reg <= '0;
            for (int i = 0; i < NUM_EVENTS; i++)
                cnt_reg[i] <= '0;
        end
        else if (cmd.load)
        begin
            for (int i = 0; i < NUM_EVENTS; i++)
            begin
                if (hit[i])
                begin
                    cnt_reg[i]  <= cnt_next;
                    fail_reg[i] <= fail_next;
                end
            end
        end
    end

    // Result register, no reset needed on payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nvm_block_id <= event_id;
            if (found)
            begin
                result_code       <= RES_ACCEPTED;
                nvm_counter_value <= cnt_next_wide[NVM_CNT_W-1:0];
                event_failed      <= fail_next;
            end
            else
            begin
                result_code       <= RES_UNKNOWN;
                nvm_counter_value <= '0;
                event_failed      <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/event_debounce_counter_table_top.sv =====
// Top level of the event debounce counter table.
// Each report beat (event id, kind) is matched against the first events_in_use
// ids of a four-entry table, lowest entry first, and updates that entry's
// debounce counter and failed flag; one result beat per report. Match,
// counter update and result register load all happen at the accepting edge,
// and the result appears the next cycle. A single output
// register holds the result, and a new report is taken in any cycle where that
// register is empty or is being read, so one report per cycle is sustained
// while the result side keeps up. Config writes are taken every cycle and
// must only be made while the block is idle.
`default_nettype none
module event_debounce_counter_table_top
    import edct_pkg::*;
#(
    parameter int NUM_EVENTS  = DEF_NUM_EVENTS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    edct_report_if.sink report,
    edct_result_if.source result,
    edct_cfg_if.sink    cfg
);

    cmd_t cmd;

    edct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (report.valid),
        .in_ready  (report.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cmd       (cmd)
    );

    edct_datapath #(
        .NUM_EVENTS  (NUM_EVENTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .event_id          (report.event_id),
        .report_kind       (report.report_kind),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .result_code       (result.result_code),
        .nvm_block_id      (result.nvm_block_id),
        .nvm_counter_value (result.nvm_counter_value),
        .event_failed      (result.event_failed)
    );

endmodule
`default_nettype wire
